[rtl/lagged_cross_correlogram_defines.svh]
`ifndef LAGGED_CROSS_CORRELOGRAM_DEFINES_SVH
`define LAGGED_CROSS_CORRELOGRAM_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define LCC_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define LCC_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/ccg_pkg.sv]
`timescale 1ns / 1ps

package ccg_pkg;

    localparam int MAX_SAMPLES_DEF = 1024;
    localparam int MAX_LAG_DEF     = 31;
    localparam int SAMPLE_BITS_DEF = 16;

    localparam int CFG_W      = 5;
    localparam int LAG_W      = 6;
    localparam int CORR_W     = 16;
    localparam int LAG_DIV    = 5;
    localparam int FRAC_BITS  = 32;
    localparam int QUOT_BITS  = 33;
    localparam int ROOT_BITS  = 17;
    localparam int CORR_MAX   = 32767;

    localparam logic [CFG_W-1:0] MAX_LAG_RESET = 5'd20;

    // control from the sequencer to the normalizer
    typedef struct packed {
        logic start;
        logic ack;
    } norm_ctl_t;

endpackage

[rtl/ccg_if.sv]
`timescale 1ns / 1ps

interface ccg_in_if #(
    parameter int SAMPLE_BITS = ccg_pkg::SAMPLE_BITS_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] x_sample;
    logic signed [SAMPLE_BITS-1:0] y_sample;
    logic                          last_in;

    modport source (output valid, x_sample, y_sample, last_in, input ready);
    modport sink (input valid, x_sample, y_sample, last_in, output ready);
endinterface

interface ccg_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [ccg_pkg::LAG_W-1:0]    lag;
    logic signed [ccg_pkg::CORR_W-1:0]   correlation;
    logic                                last_out;
    logic                                truncated;

    modport source (output valid, lag, correlation, last_out, truncated, input ready);
    modport sink (input valid, lag, correlation, last_out, truncated, output ready);
endinterface

[rtl/lagged_cross_correlogram.sv]
`timescale 1ns / 1ps
// loading: one item per cycle; a set of n items ends with the item marked last
// after it: lag limit clamping, streaming the stores through the cell row, aligning
// it, then per lag a pass through the shared bit-serial multiplier, divider and root unit
// results leave through an output register; no item is taken until the set is done
// async reset clears control, sample count and overflow flag; max_lag resets to 20
module lagged_cross_correlogram #(
    parameter int MAX_SAMPLES = ccg_pkg::MAX_SAMPLES_DEF,
    parameter int MAX_LAG     = ccg_pkg::MAX_LAG_DEF,
    parameter int SAMPLE_BITS = ccg_pkg::SAMPLE_BITS_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_wr_en,
    input  logic [ccg_pkg::CFG_W-1:0] cfg_wr_data,
    ccg_in_if.sink                    in_ch,
    ccg_out_if.source                 out_ch
);

    localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
    localparam int AW    = $clog2(MAX_SAMPLES);
    localparam int SB    = SAMPLE_BITS;
    localparam int SW    = SB + CNT_W;
    localparam int PW    = 2 * SB + CNT_W;
    localparam int NCELL = 2 * MAX_LAG + 1;
    localparam int CMP_W = (CNT_W > 8) ? CNT_W : 8;
    localparam int LW    = ccg_pkg::CFG_W;

    typedef enum logic [6:0] {
        S_LOAD  = 7'b0000001,
        S_CLAMP = 7'b0000010,
        S_RUN   = 7'b0000100,
        S_DRAIN = 7'b0001000,
        S_SKIP  = 7'b0010000,
        S_GRAB  = 7'b0100000,
        S_WAIT  = 7'b1000000
    } state_t;

    state_t                 state_reg, state_next;
    logic [LW-1:0]          max_lag_reg;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic                   ovf_reg, ovf_next;
    logic [LW-1:0]          lim_reg, lim_next;
    logic [CNT_W-1:0]       rd_idx_reg, rd_idx_next;
    logic [1:0]             drain_reg, drain_next;
    logic [LW-1:0]          skip_reg, skip_next;
    logic signed [ccg_pkg::LAG_W-1:0] lag_reg, lag_next;

    logic                   in_fire, store_we, rd_en, rd_v_reg;
    logic                   clear, shift;
    logic [CMP_W-1:0]       lim_x5;
    logic signed [ccg_pkg::LAG_W-1:0] lim_s;
    ccg_pkg::norm_ctl_t     nctl;
    logic                   ndone;
    logic signed [ccg_pkg::CORR_W-1:0] ncorr;
    logic                   out_wr;

    logic [SB-1:0]          x_rdata, y_rdata;
    logic signed [SB-1:0]   x_rd, y_rd;

    logic signed [SB-1:0]   x_tap  [MAX_LAG + 1];
    logic signed [SB-1:0]   y_tap  [MAX_LAG + 1];
    logic [2*SB-1:0]        xs_tap [MAX_LAG + 1];
    logic [2*SB-1:0]        ys_tap [MAX_LAG + 1];
    logic                   v_tap  [MAX_LAG + 1];

    logic signed [SW-1:0]   sa_w  [NCELL + 1];
    logic signed [SW-1:0]   sb_w  [NCELL + 1];
    logic signed [PW-1:0]   sab_w [NCELL + 1];
    logic signed [PW-1:0]   saa_w [NCELL + 1];
    logic signed [PW-1:0]   sbb_w [NCELL + 1];
    logic [CNT_W-1:0]       cnt_w [NCELL + 1];

    logic                   out_valid_reg;
    logic signed [ccg_pkg::LAG_W-1:0]  out_lag_reg;
    logic signed [ccg_pkg::CORR_W-1:0] out_corr_reg;
    logic                   out_last_reg, out_trunc_reg;

    assign in_ch.ready = (state_reg == S_LOAD);
    assign in_fire     = in_ch.valid && in_ch.ready;
    assign store_we    = in_fire && (cnt_reg < CNT_W'(MAX_SAMPLES));
    assign lim_x5      = (CMP_W'(lim_reg) << 2) + CMP_W'(lim_reg);
    assign lim_s       = $signed({1'b0, lim_reg});
    assign rd_en       = (state_reg == S_RUN);

    ccg_ram #(.WIDTH(SB), .DEPTH(MAX_SAMPLES)) u_x_ram (
        .clk   (clk),
        .we    (store_we),
        .waddr (cnt_reg[AW-1:0]),
        .wdata (in_ch.x_sample),
        .raddr (rd_idx_reg[AW-1:0]),
        .rdata (x_rdata)
    );

    ccg_ram #(.WIDTH(SB), .DEPTH(MAX_SAMPLES)) u_y_ram (
        .clk   (clk),
        .we    (store_we),
        .waddr (cnt_reg[AW-1:0]),
        .wdata (in_ch.y_sample),
        .raddr (rd_idx_reg[AW-1:0]),
        .rdata (y_rdata)
    );

    assign x_rd = x_rdata;
    assign y_rd = y_rdata;

    // tap 0 holds the current pair with its squares, tap s the pair s items back
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_v_reg <= 1'b0;
            for (int i = 0; i <= MAX_LAG; i++)
            begin
                v_tap[i] <= 1'b0;
            end
        end
        else if (clear)
        begin
            rd_v_reg <= 1'b0;
            for (int i = 0; i <= MAX_LAG; i++)
            begin
                v_tap[i] <= 1'b0;
            end
        end
        else
        begin
            rd_v_reg <= rd_en;
            v_tap[0] <= rd_v_reg;
            for (int i = 1; i <= MAX_LAG; i++)
            begin
                v_tap[i] <= v_tap[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        x_tap[0]  <= x_rd;
        y_tap[0]  <= y_rd;
        xs_tap[0] <= x_rd * x_rd;
        ys_tap[0] <= y_rd * y_rd;
        for (int i = 1; i <= MAX_LAG; i++)
        begin
            x_tap[i]  <= x_tap[i-1];
            y_tap[i]  <= y_tap[i-1];
            xs_tap[i] <= xs_tap[i-1];
            ys_tap[i] <= ys_tap[i-1];
        end
    end

    assign sa_w[NCELL]  = '0;
    assign sb_w[NCELL]  = '0;
    assign sab_w[NCELL] = '0;
    assign saa_w[NCELL] = '0;
    assign sbb_w[NCELL] = '0;
    assign cnt_w[NCELL] = '0;

    // cell p holds lag p - MAX_LAG; readout shifts toward cell 0
    for (genvar p = 0; p < NCELL; p++)
    begin : g_cell
        localparam int S = (p < MAX_LAG) ? (MAX_LAG - p) : (p - MAX_LAG);
        localparam bit NEG = (p < MAX_LAG);

        ccg_cell #(.SAMPLE_BITS(SB), .CNT_W(CNT_W)) u_cell (
            .clk     (clk),
            .clear   (clear),
            .acc_en  (v_tap[0] && v_tap[S]),
            .shift   (shift),
            .a       (NEG ? x_tap[S] : x_tap[0]),
            .a2      (NEG ? xs_tap[S] : xs_tap[0]),
            .b       (NEG ? y_tap[0] : y_tap[S]),
            .b2      (NEG ? ys_tap[0] : ys_tap[S]),
            .sa_in   (sa_w[p+1]),
            .sb_in   (sb_w[p+1]),
            .sab_in  (sab_w[p+1]),
            .saa_in  (saa_w[p+1]),
            .sbb_in  (sbb_w[p+1]),
            .cnt_in  (cnt_w[p+1]),
            .sa_out  (sa_w[p]),
            .sb_out  (sb_w[p]),
            .sab_out (sab_w[p]),
            .saa_out (saa_w[p]),
            .sbb_out (sbb_w[p]),
            .cnt_out (cnt_w[p])
        );
    end

    ccg_norm #(.SAMPLE_BITS(SB), .CNT_W(CNT_W)) u_norm (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (nctl),
        .m     (cnt_w[0]),
        .sa    (sa_w[0]),
        .sb    (sb_w[0]),
        .sab   (sab_w[0]),
        .saa   (saa_w[0]),
        .sbb   (sbb_w[0]),
        .done  (ndone),
        .corr  (ncorr)
    );

    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        ovf_next    = ovf_reg;
        lim_next    = lim_reg;
        rd_idx_next = rd_idx_reg;
        drain_next  = drain_reg;
        skip_next   = skip_reg;
        lag_next    = lag_reg;
        clear       = 1'b0;
        shift       = 1'b0;
        nctl        = '0;
        out_wr      = 1'b0;
        unique case (state_reg)
            S_LOAD:
            begin
                if (in_fire)
                begin
                    if (store_we)
                    begin
                        cnt_next = cnt_reg + CNT_W'(1);
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    if (in_ch.last_in)
                    begin
                        lim_next   = (max_lag_reg > LW'(MAX_LAG)) ? LW'(MAX_LAG) : max_lag_reg;
                        state_next = S_CLAMP;
                    end
                end
            end
            S_CLAMP:
            begin
                // bring the lag limit down to count / 5
                if (lim_x5 > CMP_W'(cnt_reg))
                begin
                    lim_next = lim_reg - LW'(1);
                end
                else
                begin
                    clear       = 1'b1;
                    rd_idx_next = '0;
                    skip_next   = LW'(MAX_LAG) - lim_reg;
                    state_next  = S_RUN;
                end
            end
            S_RUN:
            begin
                if (rd_idx_reg == cnt_reg - CNT_W'(1))
                begin
                    drain_next = '0;
                    state_next = S_DRAIN;
                end
                else
                begin
                    rd_idx_next = rd_idx_reg + CNT_W'(1);
                end
            end
            S_DRAIN:
            begin
                if (drain_reg == 2'd2)
                begin
                    state_next = S_SKIP;
                end
                else
                begin
                    drain_next = drain_reg + 2'd1;
                end
            end
            S_SKIP:
            begin
                if (skip_reg == '0)
                begin
                    lag_next   = -lim_s;
                    state_next = S_GRAB;
                end
                else
                begin
                    shift     = 1'b1;
                    skip_next = skip_reg - LW'(1);
                end
            end
            S_GRAB:
            begin
                nctl.start = 1'b1;
                shift      = 1'b1;
                state_next = S_WAIT;
            end
            default:
            begin
                if (ndone && (!out_valid_reg || out_ch.ready))
                begin
                    out_wr   = 1'b1;
                    nctl.ack = 1'b1;
                    if (lag_reg == lim_s)
                    begin
                        cnt_next   = '0;
                        ovf_next   = 1'b0;
                        state_next = S_LOAD;
                    end
                    else
                    begin
                        lag_next   = lag_reg + ccg_pkg::LAG_W'(1);
                        state_next = S_GRAB;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_LOAD;
            max_lag_reg   <= ccg_pkg::MAX_LAG_RESET;
            cnt_reg       <= '0;
            ovf_reg       <= 1'b0;
            lim_reg       <= '0;
            rd_idx_reg    <= '0;
            drain_reg     <= '0;
            skip_reg      <= '0;
            lag_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            if (cfg_wr_en)
            begin
                max_lag_reg <= cfg_wr_data;
            end
            cnt_reg    <= cnt_next;
            ovf_reg    <= ovf_next;
            lim_reg    <= lim_next;
            rd_idx_reg <= rd_idx_next;
            drain_reg  <= drain_next;
            skip_reg   <= skip_next;
            lag_reg    <= lag_next;
            if (out_wr)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_wr)
        begin
            out_lag_reg   <= lag_reg;
            out_corr_reg  <= ncorr;
            out_last_reg  <= (lag_reg == lim_s);
            out_trunc_reg <= ovf_reg;
        end
    end

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.lag         = out_lag_reg;
    assign out_ch.correlation = out_corr_reg;
    assign out_ch.last_out    = out_last_reg;
    assign out_ch.truncated   = out_trunc_reg;

endmodule

[rtl/ccg_ram.sv]
`timescale 1ns / 1ps

module ccg_ram #(
    parameter int WIDTH = ccg_pkg::SAMPLE_BITS_DEF,
    parameter int DEPTH = ccg_pkg::MAX_SAMPLES_DEF,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[rtl/ccg_cell.sv]
`timescale 1ns / 1ps

module ccg_cell #(
    parameter int SAMPLE_BITS = ccg_pkg::SAMPLE_BITS_DEF,
    parameter int CNT_W       = $clog2(ccg_pkg::MAX_SAMPLES_DEF + 1),
    localparam int SW         = SAMPLE_BITS + CNT_W,
    localparam int PW         = 2 * SAMPLE_BITS + CNT_W
) (
    input  logic                          clk,
    input  logic                          clear,
    input  logic                          acc_en,
    input  logic                          shift,
    input  logic signed [SAMPLE_BITS-1:0] a,
    input  logic [2*SAMPLE_BITS-1:0]      a2,
    input  logic signed [SAMPLE_BITS-1:0] b,
    input  logic [2*SAMPLE_BITS-1:0]      b2,
    input  logic signed [SW-1:0]          sa_in,
    input  logic signed [SW-1:0]          sb_in,
    input  logic signed [PW-1:0]          sab_in,
    input  logic signed [PW-1:0]          saa_in,
    input  logic signed [PW-1:0]          sbb_in,
    input  logic [CNT_W-1:0]              cnt_in,
    output logic signed [SW-1:0]          sa_out,
    output logic signed [SW-1:0]          sb_out,
    output logic signed [PW-1:0]          sab_out,
    output logic signed [PW-1:0]          saa_out,
    output logic signed [PW-1:0]          sbb_out,
    output logic [CNT_W-1:0]              cnt_out
);

    logic signed [SW-1:0]            sa_reg, sb_reg;
    logic signed [PW-1:0]            sab_reg, saa_reg, sbb_reg;
    logic [CNT_W-1:0]                cnt_reg;
    logic signed [2*SAMPLE_BITS-1:0] prod;

    assign prod = a * b;

    // accumulate pairs while streaming, then act as a shift register for readout
    always_ff @(posedge clk)
    begin
        if (clear)
        begin
            sa_reg  <= '0;
            sb_reg  <= '0;
            sab_reg <= '0;
            saa_reg <= '0;
            sbb_reg <= '0;
            cnt_reg <= '0;
        end
        else if (shift)
        begin
            sa_reg  <= sa_in;
            sb_reg  <= sb_in;
            sab_reg <= sab_in;
            saa_reg <= saa_in;
            sbb_reg <= sbb_in;
            cnt_reg <= cnt_in;
        end
        else if (acc_en)
        begin
            sa_reg  <= sa_reg + SW'(a);
            sb_reg  <= sb_reg + SW'(b);
            sab_reg <= sab_reg + PW'(prod);
            saa_reg <= saa_reg + $signed(PW'(a2));
            sbb_reg <= sbb_reg + $signed(PW'(b2));
            cnt_reg <= cnt_reg + CNT_W'(1);
        end
    end

    assign sa_out  = sa_reg;
    assign sb_out  = sb_reg;
    assign sab_out = sab_reg;
    assign saa_out = saa_reg;
    assign sbb_out = sbb_reg;
    assign cnt_out = cnt_reg;

endmodule

[rtl/ccg_norm.sv]
`timescale 1ns / 1ps

module ccg_norm #(
    parameter int SAMPLE_BITS = ccg_pkg::SAMPLE_BITS_DEF,
    parameter int CNT_W       = $clog2(ccg_pkg::MAX_SAMPLES_DEF + 1),
    localparam int SW         = SAMPLE_BITS + CNT_W,
    localparam int PW         = 2 * SAMPLE_BITS + CNT_W
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  ccg_pkg::norm_ctl_t                ctl,
    input  logic [CNT_W-1:0]                  m,
    input  logic signed [SW-1:0]              sa,
    input  logic signed [SW-1:0]              sb,
    input  logic signed [PW-1:0]              sab,
    input  logic signed [PW-1:0]              saa,
    input  logic signed [PW-1:0]              sbb,
    output logic                              done,
    output logic signed [ccg_pkg::CORR_W-1:0] corr
);

    localparam int NW  = 2 * SAMPLE_BITS + 2 * CNT_W + 2;
    localparam int PRW = 2 * NW;
    localparam int DVW = PRW + ccg_pkg::FRAC_BITS + 1;
    localparam int RB  = ccg_pkg::ROOT_BITS;
    localparam int QB  = ccg_pkg::QUOT_BITS;

    localparam logic [2:0] OP_M_SAB = 3'd0;
    localparam logic [2:0] OP_SA_SB = 3'd1;
    localparam logic [2:0] OP_M_SAA = 3'd2;
    localparam logic [2:0] OP_SA_SA = 3'd3;
    localparam logic [2:0] OP_M_SBB = 3'd4;
    localparam logic [2:0] OP_SB_SB = 3'd5;
    localparam logic [2:0] OP_NUM2  = 3'd6;
    localparam logic [2:0] OP_VAVB  = 3'd7;

    typedef enum logic [6:0] {
        N_IDLE  = 7'b0000001,
        N_LOAD  = 7'b0000010,
        N_MUL   = 7'b0000100,
        N_DIV   = 7'b0001000,
        N_SQRT  = 7'b0010000,
        N_FIN   = 7'b0100000,
        N_DONE  = 7'b1000000
    } nstate_t;

    nstate_t                   state_reg, state_next;
    logic [2:0]                op_reg, op_next;
    logic [CNT_W-1:0]          m_reg;
    logic signed [SW-1:0]      sa_reg, sb_reg;
    logic signed [PW-1:0]      sab_reg, saa_reg, sbb_reg;
    logic [PRW-1:0]            mca_reg, mca_next;
    logic [NW-1:0]             mcb_reg, mcb_next;
    logic [PRW-1:0]            acc_reg, acc_next;
    logic                      msign_reg, msign_next;
    logic [PRW-1:0]            hold_reg, hold_next;
    logic signed [NW-1:0]      num_reg, num_next;
    logic signed [NW-1:0]      va_reg, va_next;
    logic signed [NW-1:0]      vb_reg, vb_next;
    logic                      neg_reg, neg_next;
    logic [DVW-1:0]            rem_reg, rem_next;
    logic [DVW-1:0]            dsh_reg, dsh_next;
    logic [5:0]                div_cnt_reg, div_cnt_next;
    logic [QB-1:0]             q_reg, q_next;
    logic [RB-1:0]             root_reg, root_next;
    logic [RB-1:0]             probe_reg, probe_next;
    logic signed [ccg_pkg::CORR_W-1:0] corr_reg, corr_next;

    logic signed [NW-1:0]      opa, opb;
    logic [NW-1:0]             mag_a, mag_b;
    logic [PRW-1:0]            res, diff;
    logic                      ge;
    logic [RB-1:0]             trial;
    logic [2*RB-1:0]           trial_sq;
    logic [RB:0]               k_full;
    logic [RB-1:0]             k_mag;

    always_comb
    begin
        unique case (op_reg)
            OP_M_SAB:
            begin
                opa = $signed(NW'(m_reg));
                opb = NW'(sab_reg);
            end
            OP_SA_SB:
            begin
                opa = NW'(sa_reg);
                opb = NW'(sb_reg);
            end
            OP_M_SAA:
            begin
                opa = $signed(NW'(m_reg));
                opb = NW'(saa_reg);
            end
            OP_SA_SA:
            begin
                opa = NW'(sa_reg);
                opb = NW'(sa_reg);
            end
            OP_M_SBB:
            begin
                opa = $signed(NW'(m_reg));
                opb = NW'(sbb_reg);
            end
            OP_SB_SB:
            begin
                opa = NW'(sb_reg);
                opb = NW'(sb_reg);
            end
            OP_NUM2:
            begin
                opa = num_reg;
                opb = num_reg;
            end
            default:
            begin
                opa = va_reg;
                opb = vb_reg;
            end
        endcase
    end

    assign mag_a    = opa[NW-1] ? NW'(-opa) : NW'(opa);
    assign mag_b    = opb[NW-1] ? NW'(-opb) : NW'(opb);
    assign res      = msign_reg ? PRW'(-acc_reg) : acc_reg;
    assign diff     = hold_reg - res;
    assign ge       = rem_reg >= dsh_reg;
    assign trial    = root_reg | probe_reg;
    assign trial_sq = trial * trial;
    // nearest odd root bound: largest k with 2k-1 <= isqrt(q)
    assign k_full   = ((RB + 1)'(root_reg) + (RB + 1)'(1)) >> 1;
    assign k_mag    = k_full[RB-1:0];

    always_comb
    begin
        state_next   = state_reg;
        op_next      = op_reg;
        mca_next     = mca_reg;
        mcb_next     = mcb_reg;
        acc_next     = acc_reg;
        msign_next   = msign_reg;
        hold_next    = hold_reg;
        num_next     = num_reg;
        va_next      = va_reg;
        vb_next      = vb_reg;
        neg_next     = neg_reg;
        rem_next     = rem_reg;
        dsh_next     = dsh_reg;
        div_cnt_next = div_cnt_reg;
        q_next       = q_reg;
        root_next    = root_reg;
        probe_next   = probe_reg;
        corr_next    = corr_reg;
        unique case (state_reg)
            N_IDLE:
            begin
                if (ctl.start)
                begin
                    op_next    = OP_M_SAB;
                    state_next = N_LOAD;
                end
            end
            N_LOAD:
            begin
                mca_next   = PRW'(mag_a);
                mcb_next   = mag_b;
                msign_next = opa[NW-1] ^ opb[NW-1];
                acc_next   = '0;
                state_next = N_MUL;
            end
            N_MUL:
            begin
                if (mcb_reg == '0)
                begin
                    op_next    = op_reg + 3'd1;
                    state_next = N_LOAD;
                    unique case (op_reg)
                        OP_M_SAB, OP_M_SAA, OP_M_SBB:
                        begin
                            hold_next = res;
                        end
                        OP_SA_SB:
                        begin
                            num_next = $signed(diff[NW-1:0]);
                            neg_next = diff[NW-1];
                        end
                        OP_SA_SA:
                        begin
                            va_next = $signed(diff[NW-1:0]);
                        end
                        OP_SB_SB:
                        begin
                            vb_next = $signed(diff[NW-1:0]);
                            if ((va_reg == '0) || (diff[NW-1:0] == '0))
                            begin
                                corr_next  = '0;
                                state_next = N_DONE;
                            end
                        end
                        OP_NUM2:
                        begin
                            rem_next = DVW'(res) << ccg_pkg::FRAC_BITS;
                        end
                        default:
                        begin
                            dsh_next     = DVW'(res) << ccg_pkg::FRAC_BITS;
                            div_cnt_next = 6'(QB - 1);
                            state_next   = N_DIV;
                        end
                    endcase
                end
                else
                begin
                    if (mcb_reg[0])
                    begin
                        acc_next = acc_reg + mca_reg;
                    end
                    mca_next = mca_reg << 1;
                    mcb_next = mcb_reg >> 1;
                end
            end
            N_DIV:
            begin
                // restoring division, one quotient bit per cycle
                if (ge)
                begin
                    rem_next = rem_reg - dsh_reg;
                end
                q_next   = {q_reg[QB-2:0], ge};
                dsh_next = dsh_reg >> 1;
                if (div_cnt_reg == '0)
                begin
                    root_next  = '0;
                    probe_next = {1'b1, {(RB - 1){1'b0}}};
                    state_next = N_SQRT;
                end
                else
                begin
                    div_cnt_next = div_cnt_reg - 6'd1;
                end
            end
            N_SQRT:
            begin
                if (trial_sq <= (2 * RB)'(q_reg))
                begin
                    root_next = trial;
                end
                probe_next = probe_reg >> 1;
                if (probe_reg[0])
                begin
                    state_next = N_FIN;
                end
            end
            N_FIN:
            begin
                if (neg_reg)
                begin
                    corr_next = -$signed(ccg_pkg::CORR_W'(k_mag));
                end
                else if (k_mag > RB'(ccg_pkg::CORR_MAX))
                begin
                    corr_next = ccg_pkg::CORR_W'(ccg_pkg::CORR_MAX);
                end
                else
                begin
                    corr_next = $signed(ccg_pkg::CORR_W'(k_mag));
                end
                state_next = N_DONE;
            end
            default:
            begin
                if (ctl.ack)
                begin
                    state_next = N_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= N_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == N_IDLE) && ctl.start)
        begin
            m_reg   <= m;
            sa_reg  <= sa;
            sb_reg  <= sb;
            sab_reg <= sab;
            saa_reg <= saa;
            sbb_reg <= sbb;
        end
        op_reg      <= op_next;
        mca_reg     <= mca_next;
        mcb_reg     <= mcb_next;
        acc_reg     <= acc_next;
        msign_reg   <= msign_next;
        hold_reg    <= hold_next;
        num_reg     <= num_next;
        va_reg      <= va_next;
        vb_reg      <= vb_next;
        neg_reg     <= neg_next;
        rem_reg     <= rem_next;
        dsh_reg     <= dsh_next;
        div_cnt_reg <= div_cnt_next;
        q_reg       <= q_next;
        root_reg    <= root_next;
        probe_reg   <= probe_next;
        corr_reg    <= corr_next;
    end

    assign done = (state_reg == N_DONE);
    assign corr = corr_reg;

endmodule

[rtl/ccg_checker.sv]
`timescale 1ns / 1ps
`include "lagged_cross_correlogram_defines.svh"

module ccg_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              in_ready,
    input logic                              out_valid,
    input logic                              out_ready,
    input logic signed [ccg_pkg::LAG_W-1:0]  out_lag,
    input logic signed [ccg_pkg::CORR_W-1:0] out_corr,
    input logic                              out_last
);

    // a stalled result holds
    `LCC_ASSERT_NXT(a_out_hold, out_valid && !out_ready,
        out_valid && $stable(out_corr) && $stable(out_lag), "stalled result changed")

    // the closing result of a set is at a lag of zero or above
    `LCC_ASSERT_IMP(a_last_lag, out_valid && out_last, !out_lag[ccg_pkg::LAG_W-1],
        "last result at negative lag")

    // mid-set results mean no new item is taken
    `LCC_ASSERT_IMP(a_busy, out_valid && !out_last, !in_ready, "item taken during a set")

    // nothing follows the closing result until a new set is loaded
    `LCC_ASSERT_NXT(a_set_end, out_valid && out_ready && out_last, !out_valid,
        "result after end of set")

endmodule

bind lagged_cross_correlogram ccg_checker u_ccg_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_lag   (out_ch.lag),
    .out_corr  (out_ch.correlation),
    .out_last  (out_ch.last_out)
);
